>>> rtl/core/tbmc_pkg.sv
// Shared types, constants and helpers for the twelve-bit minicomputer core.
`default_nettype none

package tbmc_pkg;

   localparam int WordW     = 12;
   localparam int MemWords  = 4096;
   localparam int MemAddrW  = $clog2(MemWords);

   typedef logic [WordW-1:0]    word_type;
   typedef logic [MemAddrW-1:0] mem_addr_type;

   localparam word_type PageMask   = 12'o7600;
   localparam word_type OffsetMask = 12'o0177;
   localparam word_type AutoMask   = 12'o7770;
   localparam word_type AutoBase   = 12'o0010;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_SETPC = 2'd1,
      MODE_READ  = 2'd2,
      MODE_EXEC  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      OP_AND = 3'd0,
      OP_TAD = 3'd1,
      OP_ISZ = 3'd2,
      OP_DCA = 3'd3,
      OP_JMS = 3'd4,
      OP_JMP = 3'd5,
      OP_IOT = 3'd6,
      OP_OPR = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      ALU_AND,
      ALU_ADD,
      ALU_INC,
      ALU_GRP1
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      word_type   acc;
      logic       link;
      word_type   operand;
      word_type   micro;
   } alu_in_type;

   typedef struct packed {
      word_type word;
      logic     link;
   } alu_out_type;

   // A 12-bit address selects the word at its residue modulo the memory size.
   function automatic mem_addr_type mem_slot(input word_type a);
      mem_slot = MemAddrW'(a % MemWords);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/tbmc_req_if.sv
// Request channel interface: valid/ready handshake with the item payload.
`default_nettype none

interface tbmc_req_if;
   import tbmc_pkg::*;

   logic     valid;
   logic     ready;
   logic [1:0] mode;
   word_type address;
   word_type data;

   modport source (output valid, output mode, output address, output data, input ready);
   modport sink   (input valid, input mode, input address, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tbmc_rsp_if.sv
// Response channel interface: valid/ready handshake with the result payload.
`default_nettype none

interface tbmc_rsp_if;
   import tbmc_pkg::*;

   logic     valid;
   logic     ready;
   word_type accumulator;
   logic     link_bit;
   word_type program_counter;
   logic     halted;
   word_type read_data;
   logic     io_request;

   modport source (output valid, output accumulator, output link_bit,
                   output program_counter, output halted, output read_data,
                   output io_request, input ready);
   modport sink   (input valid, input accumulator, input link_bit,
                   input program_counter, input halted, input read_data,
                   input io_request, output ready);
endinterface

`default_nettype wire

>>> rtl/core/twelve_bit_minicomputer_core_top.sv
// Top level of the twelve-bit minicomputer core: sequencer, registers and memory.
//
// Usage. Items arrive on req_chan as beats carrying a mode, an address and a
// data word; each item yields exactly one beat on rsp_chan reporting the
// accumulator, link, program counter, halt flag, read word and IOT flag.
// A load writes one memory word, a set-PC beat loads the program counter
// and clears halt, a read returns one word, and an execute runs one
// instruction (nothing at all while halted).
// Sequencing. The block handles one item at a time and is not ready while
// it works. A load, a set-PC or a halted execute goes from ST_IDLE to
// ST_FINISH, a read passes ST_RDCAP, and an executed instruction passes
// ST_FETCH and ST_EXEC, with ST_ADDR before ST_EXEC for memory references
// and ST_IND before that for indirect or autoindexed ones; the next item is
// taken once ST_FINISH has posted the result. These steps come from the
// single memory port, used for fetch, pointer and operand in turn, and from the shared unit.
// Reset. A synchronous, active-high reset clears the accumulator, link,
// program counter, instruction register, halt flag and the sequencer. The
// memory itself is not cleared and must be written before it is read.
// Stalls. The result sits in an output register; while the receiver holds
// ready low the beat is kept stable, the block may take the next item, and
// it waits before posting the following result until that beat has gone.
`default_nettype none

module twelve_bit_minicomputer_core_top (
   input  logic           clock,
   input  logic           reset,
   tbmc_req_if.sink       req_chan,
   tbmc_rsp_if.source     rsp_chan
);
   import tbmc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RDCAP,
      ST_FETCH,
      ST_IND,
      ST_ADDR,
      ST_EXEC,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   word_type  acc_ff, acc_in;
   logic      link_ff, link_in;
   word_type  pc_ff, pc_in;
   word_type  ir_ff, ir_in;
   logic      halt_ff, halt_in;
   word_type  ea_ff, ea_in;
   word_type  rd_ff, rd_in;
   logic      io_ff, io_in;

   logic      rsp_valid_ff, rsp_valid_in;
   word_type  out_acc_ff, out_acc_in;
   logic      out_link_ff, out_link_in;
   word_type  out_pc_ff, out_pc_in;
   logic      out_halt_ff, out_halt_in;
   word_type  out_rd_ff, out_rd_in;
   logic      out_io_ff, out_io_in;

   logic         ram_en;
   logic         ram_we;
   mem_addr_type ram_addr;
   word_type     ram_wdata;
   word_type     ram_rdata;

   alu_in_type   alu_in;
   alu_out_type  alu_out;

   logic         accept;
   word_type     pc_inc;
   word_type     ea_calc;
   opcode_type   fetch_op;
   opcode_type   exec_op;
   logic         skip;

   tbmc_ram #(
      .Width (WordW),
      .Depth (MemWords)
   ) u_mem (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   tbmc_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   assign pc_inc   = pc_ff + word_type'(1);
   assign fetch_op = opcode_type'(ram_rdata[11:9]);
   assign exec_op  = opcode_type'(ir_ff[11:9]);

   // Effective address: page offset, on the page of the instruction itself
   // when the current-page bit is set. The counter has not advanced yet.
   assign ea_calc = (ram_rdata & OffsetMask) | (ram_rdata[7] ? (pc_ff & PageMask) : '0);

   // Group 2 skip test, taken on the accumulator before any clear.
   assign skip = ir_ff[3] ^ ((ir_ff[6] && acc_ff[WordW-1]) ||
                             (ir_ff[5] && (acc_ff == '0)) ||
                             (ir_ff[4] && link_ff));

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      link_in      = link_ff;
      pc_in        = pc_ff;
      ir_in        = ir_ff;
      halt_in      = halt_ff;
      ea_in        = ea_ff;
      rd_in        = rd_ff;
      io_in        = io_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      out_acc_in   = out_acc_ff;
      out_link_in  = out_link_ff;
      out_pc_in    = out_pc_ff;
      out_halt_in  = out_halt_ff;
      out_rd_in    = out_rd_ff;
      out_io_in    = out_io_ff;

      ram_en    = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = mem_slot(ea_ff);
      ram_wdata = acc_ff;

      alu_in.op      = ALU_AND;
      alu_in.acc     = acc_ff;
      alu_in.link    = link_ff;
      alu_in.operand = ram_rdata;
      alu_in.micro   = ir_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_in = '0;
               io_in = 1'b0;
               unique case (mode_type'(req_chan.mode))
                  MODE_LOAD: begin
                     ram_en    = 1'b1;
                     ram_we    = 1'b1;
                     ram_addr  = mem_slot(req_chan.address);
                     ram_wdata = req_chan.data;
                     state_in  = ST_FINISH;
                  end
                  MODE_SETPC: begin
                     pc_in    = req_chan.data;
                     halt_in  = 1'b0;
                     state_in = ST_FINISH;
                  end
                  MODE_READ: begin
                     ram_en   = 1'b1;
                     ram_addr = mem_slot(req_chan.address);
                     state_in = ST_RDCAP;
                  end
                  MODE_EXEC: begin
                     if (halt_ff) begin
                        state_in = ST_FINISH;
                     end else begin
                        ram_en   = 1'b1;
                        ram_addr = mem_slot(pc_ff);
                        state_in = ST_FETCH;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_RDCAP: begin
            rd_in    = ram_rdata;
            state_in = ST_FINISH;
         end
         ST_FETCH: begin
            ir_in = ram_rdata;
            pc_in = pc_inc;
            ea_in = ea_calc;
            if (fetch_op == OP_IOT || fetch_op == OP_OPR) begin
               state_in = ST_EXEC;
            end else if (ram_rdata[8]) begin
               ram_en   = 1'b1;
               ram_addr = mem_slot(ea_calc);
               state_in = ST_IND;
            end else begin
               state_in = ST_ADDR;
            end
         end
         ST_IND: begin
            // Pointers at words 0010 to 0017 are incremented before use.
            if ((ea_ff & AutoMask) == AutoBase) begin
               alu_in.op = ALU_INC;
               ram_en    = 1'b1;
               ram_we    = 1'b1;
               ram_wdata = alu_out.word;
               ea_in     = alu_out.word;
            end else begin
               ea_in = ram_rdata;
            end
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            ram_en   = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (exec_op)
               OP_AND: begin
                  alu_in.op = ALU_AND;
                  acc_in    = alu_out.word;
               end
               OP_TAD: begin
                  alu_in.op = ALU_ADD;
                  acc_in    = alu_out.word;
                  link_in   = alu_out.link;
               end
               OP_ISZ: begin
                  alu_in.op = ALU_INC;
                  ram_en    = 1'b1;
                  ram_we    = 1'b1;
                  ram_wdata = alu_out.word;
                  if (alu_out.word == '0) pc_in = pc_inc;
               end
               OP_DCA: begin
                  ram_en    = 1'b1;
                  ram_we    = 1'b1;
                  ram_wdata = acc_ff;
                  acc_in    = '0;
               end
               OP_JMS: begin
                  ram_en    = 1'b1;
                  ram_we    = 1'b1;
                  ram_wdata = pc_ff;
                  pc_in     = ea_ff + word_type'(1);
               end
               OP_JMP: begin
                  pc_in = ea_ff;
               end
               OP_IOT: begin
                  io_in = 1'b1;
               end
               OP_OPR: begin
                  if (!ir_ff[8]) begin
                     alu_in.op = ALU_GRP1;
                     acc_in    = alu_out.word;
                     link_in   = alu_out.link;
                  end else if (ir_ff[0]) begin
                     // Group 3: only the clear bit acts.
                     if (ir_ff[7]) acc_in = '0;
                  end else begin
                     if (skip)     pc_in   = pc_inc;
                     if (ir_ff[7]) acc_in  = '0;
                     if (ir_ff[1]) halt_in = 1'b1;
                  end
               end
               default: begin
                  acc_in = acc_ff;
               end
            endcase
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               out_acc_in   = acc_ff;
               out_link_in  = link_ff;
               out_pc_in    = pc_ff;
               out_halt_in  = halt_ff;
               out_rd_in    = rd_ff;
               out_io_in    = io_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         link_ff      <= 1'b0;
         pc_ff        <= '0;
         ir_ff        <= '0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         link_ff      <= link_in;
         pc_ff        <= pc_in;
         ir_ff        <= ir_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ea_ff       <= ea_in;
      rd_ff       <= rd_in;
      io_ff       <= io_in;
      out_acc_ff  <= out_acc_in;
      out_link_ff <= out_link_in;
      out_pc_ff   <= out_pc_in;
      out_halt_ff <= out_halt_in;
      out_rd_ff   <= out_rd_in;
      out_io_ff   <= out_io_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.accumulator     = out_acc_ff;
   assign rsp_chan.link_bit        = out_link_ff;
   assign rsp_chan.program_counter = out_pc_ff;
   assign rsp_chan.halted          = out_halt_ff;
   assign rsp_chan.read_data       = out_rd_ff;
   assign rsp_chan.io_request      = out_io_ff;

endmodule

`default_nettype wire

>>> rtl/core/tbmc_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module tbmc_ram #(
   parameter int Width = 12,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/core/tbmc_alu.sv
// Shared arithmetic unit: AND, add with link toggle, increment, operate group 1.
`default_nettype none

module tbmc_alu (
   input  tbmc_pkg::alu_in_type  alu_in,
   output tbmc_pkg::alu_out_type alu_out
);
   import tbmc_pkg::*;

   logic [WordW:0] sum;
   word_type       a;
   logic           l;
   word_type       m;

   always_comb begin
      sum = '0;
      a   = alu_in.acc;
      l   = alu_in.link;
      m   = alu_in.micro;
      case (alu_in.op)
         ALU_AND: begin
            a = alu_in.acc & alu_in.operand;
         end
         ALU_ADD: begin
            sum = {1'b0, alu_in.acc} + {1'b0, alu_in.operand};
            a   = sum[WordW-1:0];
            l   = alu_in.link ^ sum[WordW];
         end
         ALU_INC: begin
            a = alu_in.operand + word_type'(1);
         end
         ALU_GRP1: begin
            // Micro-operations apply in the fixed order of the instruction set.
            if (m[7]) a = '0;
            if (m[6]) l = 1'b0;
            if (m[5]) a = ~a;
            if (m[4]) l = ~l;
            if (m[0]) begin
               sum = {1'b0, a} + (WordW+1)'(1);
               a   = sum[WordW-1:0];
               l   = l ^ sum[WordW];
            end
            if (m[3:2] == 2'b10) begin
               {a, l} = {l, a};
               if (m[1]) {a, l} = {l, a};
            end
            if (m[3:2] == 2'b01) begin
               {l, a} = {a, l};
               if (m[1]) {l, a} = {a, l};
            end
            if (m[3:1] == 3'b001) begin
               a = {a[5:0], a[11:6]};
            end
         end
         default: begin
            a = alu_in.acc;
         end
      endcase
      alu_out.word = a;
      alu_out.link = l;
   end

endmodule

`default_nettype wire
